// ===== design/rrtse_pkg.sv =====
// rrtse_pkg: opcodes, status codes, register indexes, fixed arithmetic widths
// and sequencer state types for the RRT* tree extend block. No dependencies.
`default_nettype none
package rrtse_pkg;

  localparam logic [1:0] OP_ROOT   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_COLLIDED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_OK       = 3'd3;
  localparam logic [2:0] STAT_BAD      = 3'd4;

  localparam logic [2:0] CFG_STEP   = 3'd0;
  localparam logic [2:0] CFG_RADIUS = 3'd1;
  localparam logic [2:0] CFG_CX     = 3'd2;
  localparam logic [2:0] CFG_CY     = 3'd3;
  localparam logic [2:0] CFG_CZ     = 3'd4;
  localparam logic [2:0] CFG_HW     = 3'd5;
  localparam logic [2:0] CFG_HH     = 3'd6;

  // squared distance, its root, and the steering quotient operands
  localparam int SQ_W  = 38;
  localparam int RT_W  = 19;
  localparam int NUM_W = 36;
  localparam int DEN_W = 19;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RADSQ, ST_RADSQ2, ST_ADDR, ST_DATA, ST_SQX, ST_SQY, ST_SQZ, ST_SQE,
    ST_ROOT_GO, ST_ROOT, ST_STEER_MUL, ST_STEER_DIV, ST_STEER_WAIT, ST_COLLIDE,
    ST_READ_DATA, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PASS_NEAR, PASS_STEER, PASS_NEARCOST, PASS_PARENT, PASS_REWIRE
  } pass_t;

endpackage
`default_nettype wire

// ===== design/rrtse_req_if.sv =====
// rrtse_req_if: request channel (opcode, point, read index) with valid/ready.
// No dependencies.
`default_nettype none
interface rrtse_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [17:0] point_x;
  logic signed [17:0] point_y;
  logic signed [17:0] point_z;
  logic [9:0]         read_index;
  modport source(output valid, opcode, point_x, point_y, point_z, read_index, input ready);
  modport sink(input valid, opcode, point_x, point_y, point_z, read_index, output ready);
endinterface
`default_nettype wire

// ===== design/rrtse_rsp_if.sv =====
// rrtse_rsp_if: result channel (status and node fields) with valid/ready.
// No dependencies.
`default_nettype none
interface rrtse_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [9:0]         node_index;
  logic signed [17:0] node_pos_x;
  logic signed [17:0] node_pos_y;
  logic signed [17:0] node_pos_z;
  logic [9:0]         parent_index;
  logic [23:0]        path_cost;
  logic [10:0]        rewired_count;
  modport source(output valid, status, node_index, node_pos_x, node_pos_y, node_pos_z,
                 parent_index, path_cost, rewired_count, input ready);
  modport sink(input valid, status, node_index, node_pos_x, node_pos_y, node_pos_z,
               parent_index, path_cost, rewired_count, output ready);
endinterface
`default_nettype wire

// ===== design/rrtse_ram.sv =====
// rrtse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rrtse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/rrtse_isqrt.sv =====
// rrtse_isqrt: iterative integer square root, one root bit per cycle.
// Depends on rrtse_pkg for SQ_W and RT_W.
`default_nettype none
module rrtse_isqrt import rrtse_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] value,
  output logic                 busy,
  output logic                 done,
  output logic [RT_W-1:0]      root
);
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [SQ_W-1:0]  val;
  logic [RT_W+1:0]  rem;
  logic [CNT_W-1:0] cnt;
  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;

  assign rem_sh = {rem[RT_W-1:0], val[SQ_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CNT_W'(1);
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(RT_W);
    end else if (busy) begin
      val <= {val[SQ_W-3:0], 2'b00};
      cnt <= cnt - CNT_W'(1);
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RT_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/rrtse_div.sv =====
// rrtse_div: iterative restoring divider, one quotient bit per cycle.
// Depends on rrtse_pkg for NUM_W and DEN_W.
`default_nettype none
module rrtse_div import rrtse_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DEN_W-1:0], quot[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CNT_W'(1);
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quot <= num;
      dreg <= den;
      rem  <= '0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      rem  <= fits ? (rem_sh - {1'b0, dreg}) : rem_sh;
      quot <= {quot[NUM_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== design/rrt_star_tree_extend.sv =====
// rrt_star_tree_extend: 3-D RRT* tree store with nearest search, steering,
// parent choice, box collision test and rewiring under one small sequencer.
// Depends on rrtse_pkg, rrtse_req_if, rrtse_rsp_if, rrtse_ram, rrtse_isqrt, rrtse_div.
//
// Usage:
//   req carries one command per transfer: opcode 0 clears the tree and places
//   the root, opcode 1 extends the tree toward point_x/y/z, opcode 2 reads the
//   node at read_index. Every command yields exactly one transfer on rsp.
//   The cfg port writes steer length, neighbour radius and the obstacle box;
//   write it only while no command is in flight.
// Flow:
//   req.ready is high only while the sequencer idles. A sample runs a
//   nearest pass over the stored nodes, steering (three divides, one per
//   axis, when the sample lies beyond the step length), a parent pass and a
//   rewire pass over the nodes, with a square root for the nearest node and
//   for each node within the radius. The shared multiplier, the bit-serial
//   square root and the single RAM read port set how long a command takes.
// Reset: rst clears the node count and loads the default registers; the node
//   RAM is not cleared, since only entries below the count are ever read.
// Stall: a finished result sits in an output register; the next command is
//   taken meanwhile, and the sequencer holds its own result until rsp frees.
`default_nettype none
module rrt_star_tree_extend import rrtse_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int FRAC_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  rrtse_req_if.sink        req,
  rrtse_rsp_if.source      rsp
);
  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int WW = IW + 78;

  // register defaults scaled to the fraction width
  localparam logic [31:0] RST_STEP = 32'(1) << FRAC_BITS;
  localparam logic [31:0] RST_RAD  = 32'(2) << FRAC_BITS;
  localparam logic [31:0] RST_CXY  = ((32'(9) << FRAC_BITS) + 32'd50) / 32'd100;
  localparam logic [31:0] RST_CZ   = ((32'(4) << FRAC_BITS) + 32'd50) / 32'd100;
  localparam logic [31:0] RST_HH   = ((32'(12) << FRAC_BITS) + 32'd500) / 32'd1000;

  localparam logic [23:0] COST_MAX = 24'hFFFFFF;

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [RT_W-1:0] b);
    logic [24:0] s;
    s = {1'b0, a} + 25'(b);
    return s[24] ? COST_MAX : s[23:0];
  endfunction

  function automatic logic [18:0] abs19(input logic signed [18:0] v);
    return v[18] ? 19'(-v) : 19'(v);
  endfunction

  // configuration
  logic [16:0]        step_len, radius, half_w, half_h;
  logic signed [17:0] cx, cy, cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_len <= RST_STEP[16:0];
      radius   <= RST_RAD[16:0];
      cx       <= RST_CXY[17:0];
      cy       <= RST_CXY[17:0];
      cz       <= RST_CZ[17:0];
      half_w   <= RST_CZ[16:0];
      half_h   <= RST_HH[16:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP:   step_len <= cfg_data[16:0];
        CFG_RADIUS: radius   <= cfg_data[16:0];
        CFG_CX:     cx       <= cfg_data;
        CFG_CY:     cy       <= cfg_data;
        CFG_CZ:     cz       <= cfg_data;
        CFG_HW:     half_w   <= cfg_data[16:0];
        CFG_HH:     half_h   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t             state, state_next;
  pass_t              pass;
  logic [IW-1:0]      idx, near, best;
  logic [CW-1:0]      node_count, n_lim, rew;
  logic signed [17:0] samp_x, samp_y, samp_z, new_x, new_y, new_z;
  logic signed [17:0] near_x, near_y, near_z, nd_x, nd_y, nd_z;
  logic [23:0]        near_cost, nd_cost, best_cost;
  logic signed [18:0] dlt_x, dlt_y, dlt_z;
  logic [SQ_W-1:0]    acc, bsq, rad_sq, sqv, prod;
  logic [RT_W-1:0]    steer_d;
  logic [1:0]         axis;

  // result staging and output registers
  logic [2:0]         res_status, out_status;
  logic [9:0]         res_index, out_index, res_parent, out_parent;
  logic signed [17:0] res_x, res_y, res_z, out_x, out_y, out_z;
  logic [23:0]        res_cost, out_cost;
  logic [10:0]        out_rew;
  logic               out_valid;

  // shared units
  logic [18:0]        mul_a, mul_b;
  logic               sq_start, sq_busy, sq_done;
  logic [RT_W-1:0]    root;
  logic               div_start, div_busy, div_done;
  logic [NUM_W-1:0]   quot;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [WW-1:0]      ram_wdata, ram_rdata;

  logic signed [17:0] rd_x, rd_y, rd_z;
  logic [23:0]        rd_cost;
  logic [IW-1:0]      rd_parent;

  assign rd_parent = ram_rdata[IW-1:0];
  assign rd_cost   = ram_rdata[IW+23:IW];
  assign rd_z      = ram_rdata[IW+41:IW+24];
  assign rd_y      = ram_rdata[IW+59:IW+42];
  assign rd_x      = ram_rdata[IW+77:IW+60];

  rrtse_ram #(.WIDTH(WW), .DEPTH(MAX_NODES)) u_nodes (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  rrtse_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sqv),
    .busy(sq_busy), .done(sq_done), .root(root)
  );

  rrtse_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod[NUM_W-1:0]), .den(steer_d),
    .busy(div_busy), .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // derived decisions
  logic               req_xfer, out_free, idx_last, in_rad, full, read_ok, hit, skip;
  logic [CW-1:0]      lim;
  logic [SQ_W-1:0]    sq_sum;
  logic [23:0]        c_near, c_par, c_rew;
  logic signed [17:0] tgt_x, tgt_y, tgt_z, src_x, src_y, src_z, st_from, st_to;
  logic signed [18:0] st_delta;
  logic [18:0]        st_mag;
  logic signed [19:0] st_new;

  assign req_xfer = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign lim      = (pass == PASS_REWIRE) ? n_lim : node_count;
  assign idx_last = (CW'(idx) + CW'(1)) == lim;
  assign sq_sum   = acc + prod;
  assign in_rad   = sq_sum < rad_sq;
  assign full     = node_count >= CW'(MAX_NODES);
  assign read_ok  = {22'd0, req.read_index} < 32'(node_count);
  assign skip     = (pass == PASS_REWIRE) && (idx == best);
  assign c_near   = sat_add(near_cost, root);
  assign c_par    = sat_add(nd_cost, root);
  assign c_rew    = sat_add(best_cost, root);

  assign tgt_x = (pass == PASS_NEAR) ? samp_x : new_x;
  assign tgt_y = (pass == PASS_NEAR) ? samp_y : new_y;
  assign tgt_z = (pass == PASS_NEAR) ? samp_z : new_z;
  assign src_x = (pass == PASS_NEARCOST) ? near_x : rd_x;
  assign src_y = (pass == PASS_NEARCOST) ? near_y : rd_y;
  assign src_z = (pass == PASS_NEARCOST) ? near_z : rd_z;

  always_comb begin
    case (axis)
      2'd0:    begin st_from = near_x; st_to = samp_x; end
      2'd1:    begin st_from = near_y; st_to = samp_y; end
      default: begin st_from = near_z; st_to = samp_z; end
    endcase
  end
  assign st_delta = 19'(st_to) - 19'(st_from);
  assign st_mag   = abs19(st_delta);
  assign st_new   = 20'(st_from) + (st_delta[18] ? -20'(quot[18:0]) : 20'(quot[18:0]));

  assign hit = (abs19(19'(new_x) - 19'(cx)) < {2'b00, half_w}) &&
               (abs19(19'(new_y) - 19'(cy)) < {2'b00, half_w}) &&
               (abs19(19'(new_z) - 19'(cz)) < {2'b00, half_h});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit controls
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = {nd_x, nd_y, nd_z, c_rew, IW'(n_lim)};
    ram_raddr  = idx;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = IW'(req.read_index);
        if (req_xfer) begin
          case (req.opcode)
            OP_ROOT: begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = {req.point_x, req.point_y, req.point_z, 24'd0, {IW{1'b0}}};
              state_next = ST_FINISH;
            end
            OP_READ:   state_next = read_ok ? ST_READ_DATA : ST_FINISH;
            OP_SAMPLE: state_next = (node_count == '0 || full) ? ST_FINISH : ST_RADSQ;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_RADSQ: begin
        mul_a      = {2'b00, radius};
        mul_b      = {2'b00, radius};
        state_next = ST_RADSQ2;
      end
      ST_RADSQ2: state_next = ST_ADDR;
      ST_ADDR: begin
        if (skip) begin
          state_next = idx_last ? ST_FINISH : ST_ADDR;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: state_next = ST_SQX;
      ST_SQX: begin
        mul_a      = abs19(dlt_x);
        mul_b      = abs19(dlt_x);
        state_next = ST_SQY;
      end
      ST_SQY: begin
        mul_a      = abs19(dlt_y);
        mul_b      = abs19(dlt_y);
        state_next = ST_SQZ;
      end
      ST_SQZ: begin
        mul_a      = abs19(dlt_z);
        mul_b      = abs19(dlt_z);
        state_next = ST_SQE;
      end
      ST_SQE: begin
        case (pass)
          PASS_NEAR:     state_next = idx_last ? ST_ROOT_GO : ST_ADDR;
          PASS_NEARCOST: state_next = ST_ROOT_GO;
          PASS_PARENT:   state_next = in_rad ? ST_ROOT_GO : (idx_last ? ST_COLLIDE : ST_ADDR);
          PASS_REWIRE:   state_next = in_rad ? ST_ROOT_GO : (idx_last ? ST_FINISH : ST_ADDR);
          default:       state_next = ST_IDLE;
        endcase
      end
      ST_ROOT_GO: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          case (pass)
            PASS_STEER:    state_next = (root <= 19'(step_len)) ? ST_DATA : ST_STEER_MUL;
            PASS_NEARCOST: state_next = ST_ADDR;
            PASS_PARENT:   state_next = idx_last ? ST_COLLIDE : ST_ADDR;
            PASS_REWIRE: begin
              if (c_rew < nd_cost) begin
                ram_we = 1'b1;
              end
              state_next = idx_last ? ST_FINISH : ST_ADDR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_STEER_MUL: begin
        mul_a      = st_mag;
        mul_b      = {2'b00, step_len};
        state_next = ST_STEER_DIV;
      end
      ST_STEER_DIV: begin
        div_start  = 1'b1;
        state_next = ST_STEER_WAIT;
      end
      ST_STEER_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? ST_DATA : ST_STEER_MUL;
        end
      end
      ST_COLLIDE: begin
        if (!hit) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(node_count);
          ram_wdata = {new_x, new_y, new_z, best_cost, best};
        end
        state_next = hit ? ST_FINISH : ST_ADDR;
      end
      ST_READ_DATA: state_next = ST_FINISH;
      ST_FINISH:    state_next = out_free ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  // node count
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (state == ST_IDLE && req_xfer && req.opcode == OP_ROOT) begin
      node_count <= CW'(1);
    end else if (state == ST_COLLIDE && !hit) begin
      node_count <= node_count + CW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          samp_x     <= req.point_x;
          samp_y     <= req.point_y;
          samp_z     <= req.point_z;
          idx        <= '0;
          pass       <= PASS_NEAR;
          rew        <= '0;
          res_status <= (req.opcode == OP_ROOT) ? STAT_OK :
                        (req.opcode == OP_SAMPLE && node_count != '0 && full) ? STAT_FULL :
                        STAT_BAD;
          // a read past the end reports index zero
          res_index  <= (req.opcode == OP_READ && read_ok) ? req.read_index : 10'd0;
          res_x      <= (req.opcode == OP_ROOT) ? req.point_x : 18'sd0;
          res_y      <= (req.opcode == OP_ROOT) ? req.point_y : 18'sd0;
          res_z      <= (req.opcode == OP_ROOT) ? req.point_z : 18'sd0;
          res_parent <= '0;
          res_cost   <= '0;
        end
      end
      ST_RADSQ2: rad_sq <= prod;
      ST_ADDR: begin
        if (skip && !idx_last) begin
          idx <= idx + IW'(1);
        end
      end
      ST_DATA: begin
        nd_x    <= src_x;
        nd_y    <= src_y;
        nd_z    <= src_z;
        nd_cost <= (pass == PASS_NEARCOST) ? near_cost : rd_cost;
        dlt_x   <= 19'(tgt_x) - 19'(src_x);
        dlt_y   <= 19'(tgt_y) - 19'(src_y);
        dlt_z   <= 19'(tgt_z) - 19'(src_z);
      end
      ST_SQY: acc <= prod;
      ST_SQZ: acc <= acc + prod;
      ST_SQE: begin
        // nearest pass keeps the running minimum for the root step
        sqv <= (pass == PASS_NEAR && !(idx == '0 || sq_sum < bsq)) ? bsq : sq_sum;
        case (pass)
          PASS_NEAR: begin
            if (idx == '0 || sq_sum < bsq) begin
              bsq       <= sq_sum;
              near      <= idx;
              near_x    <= nd_x;
              near_y    <= nd_y;
              near_z    <= nd_z;
              near_cost <= nd_cost;
            end
            if (idx_last) begin
              pass <= PASS_STEER;
            end else begin
              idx <= idx + IW'(1);
            end
          end
          PASS_PARENT, PASS_REWIRE: begin
            if (!in_rad && !idx_last) begin
              idx <= idx + IW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_ROOT: begin
        if (sq_done) begin
          case (pass)
            PASS_STEER: begin
              steer_d <= root;
              axis    <= 2'd0;
              if (root <= 19'(step_len)) begin
                new_x <= samp_x;
                new_y <= samp_y;
                new_z <= samp_z;
                pass  <= PASS_NEARCOST;
              end
            end
            PASS_NEARCOST: begin
              best_cost <= c_near;
              best      <= near;
              idx       <= '0;
              pass      <= PASS_PARENT;
            end
            PASS_PARENT: begin
              if (c_par < best_cost) begin
                best_cost <= c_par;
                best      <= idx;
              end
              if (!idx_last) begin
                idx <= idx + IW'(1);
              end
            end
            PASS_REWIRE: begin
              if (c_rew < nd_cost) begin
                rew <= rew + CW'(1);
              end
              if (!idx_last) begin
                idx <= idx + IW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_STEER_WAIT: begin
        if (div_done) begin
          case (axis)
            2'd0:    new_x <= st_new[17:0];
            2'd1:    new_y <= st_new[17:0];
            default: new_z <= st_new[17:0];
          endcase
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            pass <= PASS_NEARCOST;
          end
        end
      end
      ST_COLLIDE: begin
        res_status <= hit ? STAT_COLLIDED : STAT_INSERTED;
        res_index  <= hit ? 10'd0 : 10'(node_count);
        res_x      <= new_x;
        res_y      <= new_y;
        res_z      <= new_z;
        res_parent <= 10'(best);
        res_cost   <= best_cost;
        n_lim      <= node_count;
        idx        <= '0;
        pass       <= PASS_REWIRE;
      end
      ST_READ_DATA: begin
        res_status <= STAT_OK;
        res_x      <= rd_x;
        res_y      <= rd_y;
        res_z      <= rd_z;
        res_parent <= 10'(rd_parent);
        res_cost   <= rd_cost;
      end
      default: ;
    endcase
  end

  // output register: load when the previous result has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_x      <= res_x;
      out_y      <= res_y;
      out_z      <= res_z;
      out_parent <= res_parent;
      out_cost   <= res_cost;
      out_rew    <= 11'(rew);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.node_index    = out_index;
  assign rsp.node_pos_x    = out_x;
  assign rsp.node_pos_y    = out_y;
  assign rsp.node_pos_z    = out_z;
  assign rsp.parent_index  = out_parent;
  assign rsp.path_cost     = out_cost;
  assign rsp.rewired_count = out_rew;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CW'(MAX_NODES))
    else $error("node count beyond capacity");

  a_write_in_tree: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> CW'(ram_waddr) <= node_count)
    else $error("node write beyond the end of the tree");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_busy)
    else $error("square root started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divide started while busy");

endmodule
`default_nettype wire
